[src/dual_pattern_eds_shift_and_matcher_assert.svh]
// Assertion macros shared by the matcher RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef DUAL_PATTERN_EDS_SHIFT_AND_MATCHER_ASSERT_SVH
`define DUAL_PATTERN_EDS_SHIFT_AND_MATCHER_ASSERT_SVH

`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset.
`define DPM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dpm assertion failed");
// Condition never holds at a clock edge outside reset.
`define DPM_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("dpm forbidden condition seen");
`else
`define DPM_ASSERT(lbl, clk, rst_n, prop)
`define DPM_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

[src/dpm_pkg.sv]
// Shared types, codes and helpers of the dual-pattern shift-and matcher.
// No dependencies.
package dpm_pkg;

    localparam int VEC_W   = 32;
    localparam int LEN_W   = 6;
    localparam int SYM_W   = 8;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [LEN_W-1:0] LEN_RESET   = 6'd3;
    localparam logic [VEC_W-1:0] MERGE_RESET = 32'h2492_4924;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MERGE_MASK     = 2'd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD       = 3'd0,
        OP_SEG_START  = 3'd1,
        OP_ELEM_START = 3'd2,
        OP_SYMBOL     = 3'd3,
        OP_ELEM_END   = 3'd4,
        OP_CLEAR      = 3'd5
    } t_opcode;

    // One beat in the update stage, as seen by the state core.
    typedef struct packed {
        logic    fire;
        t_opcode op;
        logic    sym_ok;
    } t_step;

    // Match bit for a pattern length, with zero acting as one and the
    // length clamped to the vector width and the configured maximum.
    function automatic logic [VEC_W-1:0] match_mask_of(logic [LEN_W-1:0] len,
                                                       int max_len);
        int               lim;
        logic [LEN_W-1:0] eff;
        lim = (max_len < VEC_W) ? max_len : VEC_W;
        eff = (len == '0) ? 6'd1 : len;
        if (int'(eff) > lim) begin
            eff = LEN_W'(lim);
        end
        return VEC_W'(1) << (eff - 6'd1);
    endfunction

endpackage

[src/dpm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dpm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/dpm_core.sv]
// State vectors, segment registers and occurrence counter of the matcher.
// Depends on dpm_pkg and the assertion macro header.
`include "dual_pattern_eds_shift_and_matcher_assert.svh"

module dpm_core
    import dpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_step            i_step,
    input  logic [VEC_W-1:0] i_tab_first,
    input  logic [VEC_W-1:0] i_tab_second,
    input  logic [VEC_W-1:0] i_merge_mask,
    input  logic [VEC_W-1:0] i_match_mask,
    output logic             o_hit,
    output logic [VEC_W-1:0] o_count_next
);

    logic [VEC_W-1:0] r_entry_f, r_entry_s, n_entry_f, n_entry_s;
    logic [VEC_W-1:0] r_accum_f, r_accum_s, n_accum_f, n_accum_s;
    logic [VEC_W-1:0] r_cur_f, r_cur_s, n_cur_f, n_cur_s;
    logic [VEC_W-1:0] r_count, n_count;
    logic [VEC_W-1:0] tf, ts, adv_f, adv_s;
    logic             hit;

    // Shift-and step with cross-merge from the other vector.
    always_comb begin
        tf    = i_step.sym_ok ? i_tab_first  : '0;
        ts    = i_step.sym_ok ? i_tab_second : '0;
        adv_f = (((r_cur_f | (r_cur_s & i_merge_mask)) << 1) | VEC_W'(1)) & tf;
        adv_s = (((r_cur_s | (r_cur_f & i_merge_mask)) << 1) | VEC_W'(1)) & ts;
        hit   = |((adv_f | adv_s) & i_match_mask);
    end

    // Next state for each command.
    always_comb begin
        n_entry_f = r_entry_f;
        n_entry_s = r_entry_s;
        n_accum_f = r_accum_f;
        n_accum_s = r_accum_s;
        n_cur_f   = r_cur_f;
        n_cur_s   = r_cur_s;
        n_count   = r_count;
        o_hit     = 1'b0;
        unique case (i_step.op)
            OP_SEG_START: begin
                n_entry_f = r_accum_f;
                n_entry_s = r_accum_s;
                n_accum_f = '0;
                n_accum_s = '0;
            end
            OP_ELEM_START: begin
                n_cur_f = r_entry_f;
                n_cur_s = r_entry_s;
            end
            OP_SYMBOL: begin
                n_cur_f = adv_f;
                n_cur_s = adv_s;
                o_hit   = hit;
                n_count = r_count + VEC_W'(hit);
            end
            OP_ELEM_END: begin
                n_accum_f = r_accum_f | r_cur_f;
                n_accum_s = r_accum_s | r_cur_s;
            end
            OP_CLEAR: begin
                n_entry_f = '0;
                n_entry_s = '0;
                n_accum_f = '0;
                n_accum_s = '0;
                n_cur_f   = '0;
                n_cur_s   = '0;
                n_count   = '0;
            end
            default: begin
                // Mask loads and unused codes leave the state alone.
            end
        endcase
        o_count_next = n_count;
    end

    // State registers advance once per beat leaving the update stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_f <= '0;
            r_entry_s <= '0;
            r_accum_f <= '0;
            r_accum_s <= '0;
            r_cur_f   <= '0;
            r_cur_s   <= '0;
            r_count   <= '0;
        end else if (i_step.fire) begin
            r_entry_f <= n_entry_f;
            r_entry_s <= n_entry_s;
            r_accum_f <= n_accum_f;
            r_accum_s <= n_accum_s;
            r_cur_f   <= n_cur_f;
            r_cur_s   <= n_cur_s;
            r_count   <= n_count;
        end
    end

    // The counter moves only when a beat is processed.
    `DPM_ASSERT(a_count_idle, i_clk, i_rst_n, !i_step.fire |=> $stable(r_count))
    // A hit on a symbol beat adds exactly one to the count.
    `DPM_ASSERT(a_hit_counts, i_clk, i_rst_n,
                (i_step.fire && i_step.op == OP_SYMBOL && hit) |=>
                (r_count == $past(r_count) + VEC_W'(1)))

endmodule

[src/dual_pattern_eds_shift_and_matcher.sv]
// Top level of the dual-pattern shift-and matcher: handshakes, mask RAM,
// configuration registers and output register. Depends on dpm_pkg,
// dpm_ram, dpm_core and the assertion macro header.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+--------------------------------
//   in       | input     | i_in_valid / o_in_ready    | opcode, symbol, mask_first/second
//   out      | output    | o_out_valid / i_out_ready  | match, match_count
//   cfg      | input     | i_cfg_wr_en (no wait)      | i_cfg_idx, i_cfg_wdata
//
// One beat per cycle sustained while the output is not stalled; a result passes
// through the update stage register and then the output register. The mask RAM
// read is issued at the accepting edge (registered read), and the next cycle runs
// the shift-and update and, unless the output is stalled, loads the output register.
// Mask loads write the RAM at acceptance, so a following symbol sees them.
// When the output is stalled, the update stage holds one beat and the input
// takes one more beat into it only once the output register frees up.
// Synchronous active-low reset; the mask RAM is not cleared.
`include "dual_pattern_eds_shift_and_matcher_assert.svh"

module dual_pattern_eds_shift_and_matcher
    import dpm_pkg::*;
#(
    parameter int ALPHABET_SIZE   = 256,
    parameter int MAX_PATTERN_LEN = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [OP_W-1:0]      i_opcode,
    input  logic [SYM_W-1:0]     i_symbol,
    input  logic [VEC_W-1:0]     i_mask_first,
    input  logic [VEC_W-1:0]     i_mask_second,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_match,
    output logic [VEC_W-1:0]     o_match_count,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VEC_W-1:0]     i_cfg_wdata
);

    localparam int ADDR_W = $clog2(ALPHABET_SIZE);

    logic             in_fire, s1_adv, sym_ok, ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0] ram_addr;
    logic [2*VEC_W-1:0] ram_rd_data;
    t_opcode          in_op;
    t_step            step;
    logic             hit;
    logic [VEC_W-1:0] count_next;

    logic             r_s1_valid;
    t_opcode          r_s1_op;
    logic             r_s1_sym_ok;
    logic             r_out_valid, r_match;
    logic [VEC_W-1:0] r_count_out;
    logic [VEC_W-1:0] r_match_mask, r_merge_mask;

    // Handshake: the update stage moves when the output register is free.
    assign s1_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_op      = t_opcode'(i_opcode);

    // Mask RAM access at acceptance.
    assign sym_ok    = {1'b0, i_symbol} < (SYM_W + 1)'(ALPHABET_SIZE);
    assign ram_addr  = i_symbol[ADDR_W-1:0];
    assign ram_wr_en = in_fire && (in_op == OP_LOAD) && sym_ok;
    assign ram_rd_en = in_fire && (in_op == OP_SYMBOL);

    dpm_ram #(
        .WIDTH (2 * VEC_W),
        .DEPTH (ALPHABET_SIZE)
    ) u_mask_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_addr),
        .i_wr_data ({i_mask_second, i_mask_first}),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_addr),
        .o_rd_data (ram_rd_data)
    );

    // Update stage bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op     <= in_op;
            r_s1_sym_ok <= sym_ok;
        end
    end

    assign step.fire   = r_s1_valid && s1_adv;
    assign step.op     = r_s1_op;
    assign step.sym_ok = r_s1_sym_ok;

    dpm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_tab_first  (ram_rd_data[VEC_W-1:0]),
        .i_tab_second (ram_rd_data[2*VEC_W-1:VEC_W]),
        .i_merge_mask (r_merge_mask),
        .i_match_mask (r_match_mask),
        .o_hit        (hit),
        .o_count_next (count_next)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step.fire) begin
            r_match     <= hit;
            r_count_out <= count_next;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match       = r_match;
    assign o_match_count = r_count_out;

    // Configuration registers; the length is kept as its decoded match bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_mask <= match_mask_of(LEN_RESET, MAX_PATTERN_LEN);
            r_merge_mask <= MERGE_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_idx == CFG_PATTERN_LENGTH) begin
                r_match_mask <= match_mask_of(i_cfg_wdata[LEN_W-1:0], MAX_PATTERN_LEN);
            end else if (i_cfg_idx == CFG_MERGE_MASK) begin
                r_merge_mask <= i_cfg_wdata;
            end
        end
    end

    // Input stalls only when both stages are full and the output is held.
    `DPM_NEVER(a_stall_cause, i_clk, i_rst_n,
               !o_in_ready && !(r_s1_valid && r_out_valid && !i_out_ready))
    // The RAM read data must not move under a beat waiting in the update stage.
    `DPM_NEVER(a_rd_hold, i_clk, i_rst_n, r_s1_valid && !s1_adv && ram_rd_en)

endmodule
